@@ rtl/core/tft_window_glyph_byte_writer_defines.svh @@
// ----------------------------------------------------------------------------
// TFT window/glyph byte writer - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TFT_WINDOW_GLYPH_BYTE_WRITER_DEFINES_SVH
`define TFT_WINDOW_GLYPH_BYTE_WRITER_DEFINES_SVH

// Property that must hold in the same cycle
`define TFTGW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent
`define TFTGW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tftgw_pkg.sv @@
// ----------------------------------------------------------------------------
// tftgw_pkg
// Types and constants shared by the TFT window/glyph byte writer.
// ----------------------------------------------------------------------------
package tftgw_pkg;

  // Request modes
  typedef enum logic [1:0] {
    MODE_WINDOW = 2'd0,
    MODE_GLYPH  = 2'd1,
    MODE_PIXEL  = 2'd2,
    MODE_RAW    = 2'd3
  } mode_t;

  // Panel commands
  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

  // Byte index within a run; covers the longest glyph row (64 bytes)
  localparam int IDX_W     = 6;
  localparam int PAYLOAD_W = 64;

  // Set window byte positions, and the last byte index of the other runs
  localparam logic [IDX_W-1:0] WIN_IDX_COL   = IDX_W'(0);
  localparam logic [IDX_W-1:0] WIN_IDX_ROW   = IDX_W'(5);
  localparam logic [IDX_W-1:0] WIN_IDX_MEMWR = IDX_W'(10);
  localparam logic [IDX_W-1:0] NARROW_LAST   = IDX_W'(31);
  localparam logic [IDX_W-1:0] PIXEL_LAST    = IDX_W'(1);
  localparam logic [IDX_W-1:0] RAW_LAST      = IDX_W'(0);

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_RGB     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RGB     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDE = 2'd2;
  localparam logic [15:0] FG_RESET   = 16'hFFFF;
  localparam logic [15:0] BG_RESET   = 16'h0000;
  localparam logic        WIDE_RESET = 1'b1;

  // Request queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Classified request: bytes come off the top of the payload
  typedef struct packed {
    mode_t                  mode;
    logic                   raw_is_data;
    logic [IDX_W-1:0]       last_idx;
    logic [PAYLOAD_W-1:0]   payload;
  } req_t;

  // Live configuration
  typedef struct packed {
    logic [15:0] fg_rgb;
    logic [15:0] bg_rgb;
    logic        glyph_wide;
  } cfg_t;

endpackage

@@ rtl/core/tftgw_front.sv @@
// ----------------------------------------------------------------------------
// tftgw_front
// Accepts drawing requests and classifies them into packed byte jobs.
// ----------------------------------------------------------------------------
module tftgw_front
  import tftgw_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_col_first,
  input  logic [15:0] in_row_first,
  input  logic [15:0] in_col_last,
  input  logic [15:0] in_row_last,
  input  logic [31:0] in_glyph_bits,
  input  logic [15:0] in_pixel_color,
  input  logic [7:0]  in_raw_value,
  input  logic        in_raw_is_data,
  output logic        f_valid,
  output req_t        f_req,
  input  logic        q_full
);

  // Wide glyph width, kept within 16..32 pixels
  localparam int GLYPH_W   = (MAX_GLYPH_WIDTH < 16) ? 16 :
                             ((MAX_GLYPH_WIDTH > 32) ? 32 : MAX_GLYPH_WIDTH);
  localparam int GLYPH_PAD = 32 - GLYPH_W;
  localparam logic [IDX_W-1:0] WIDE_LAST = IDX_W'(2 * GLYPH_W - 1);

  logic        f_valid_r;
  req_t        f_req_r;
  req_t        req_nxt;
  logic [31:0] glyph_aligned;
  logic        accept;
  logic        push;

  assign push     = f_valid_r && !q_full;
  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  // Leftmost pixel moved to bit 31
  assign glyph_aligned = cfg.glyph_wide ? (in_glyph_bits << GLYPH_PAD)
                                        : {in_glyph_bits[15:0], 16'h0000};

  // Classify
  always_comb begin
    req_nxt             = '0;
    req_nxt.mode        = mode_t'(in_mode);
    req_nxt.raw_is_data = in_raw_is_data;
    unique case (mode_t'(in_mode))
      MODE_WINDOW: begin
        req_nxt.last_idx = WIN_IDX_MEMWR;
        req_nxt.payload  = {in_col_first, in_col_last, in_row_first, in_row_last};
      end
      MODE_GLYPH: begin
        req_nxt.last_idx = cfg.glyph_wide ? WIDE_LAST : NARROW_LAST;
        req_nxt.payload  = {glyph_aligned, 32'h0};
      end
      MODE_PIXEL: begin
        req_nxt.last_idx = PIXEL_LAST;
        req_nxt.payload  = {in_pixel_color, 48'h0};
      end
      MODE_RAW: begin
        req_nxt.last_idx = RAW_LAST;
        req_nxt.payload  = {in_raw_value, 56'h0};
      end
      default: begin
        req_nxt.last_idx = RAW_LAST;
      end
    endcase
  end

  // Holding stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_req_r <= req_nxt;
    end
  end

  assign f_valid = f_valid_r;
  assign f_req   = f_req_r;

endmodule

@@ rtl/core/tftgw_queue.sv @@
// ----------------------------------------------------------------------------
// tftgw_queue
// Short request queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
`include "tft_window_glyph_byte_writer_defines.svh"

module tftgw_queue
  import tftgw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic f_valid,
  input  req_t f_req,
  output logic q_full,
  output logic q_valid,
  output req_t q_req,
  input  logic q_pop
);

  req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign push    = f_valid && !q_full;
  assign pop     = q_pop && q_valid;
  assign q_req   = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= f_req;
    end
  end

  `TFTGW_ASSERT(a_cnt_bound, cnt_r <= QCNT_W'(QDEPTH), "queue count over depth")
  `TFTGW_ASSERT_NEXT(a_cnt_drop, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "pop lost")

endmodule

@@ rtl/core/tftgw_back.sv @@
// ----------------------------------------------------------------------------
// tftgw_back
// Byte sequencer: walks one request a byte per cycle into the output register, unless stalled.
// ----------------------------------------------------------------------------
`include "tft_window_glyph_byte_writer_defines.svh"

module tftgw_back
  import tftgw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  req_t       q_req,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last
);

  logic                 cur_valid_r;
  req_t                 cur_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_is_data_r;
  logic                 out_last_r;
  logic [PAYLOAD_W-1:0] pay_nxt;
  logic [7:0]           byte_cur;
  logic                 data_cur;
  logic                 is_last;
  logic                 adv;
  logic [15:0]          pix_color;

  assign is_last   = (idx_r == cur_r.last_idx);
  assign adv       = cur_valid_r && (!out_valid_r || !out_stall);
  assign q_pop     = q_valid && (!cur_valid_r || (adv && is_last));
  assign pix_color = cur_r.payload[PAYLOAD_W-1] ? cfg.fg_rgb : cfg.bg_rgb;

  // Current byte and payload advance
  always_comb begin
    byte_cur = cur_r.payload[PAYLOAD_W-1 -: 8];
    data_cur = 1'b1;
    pay_nxt  = cur_r.payload << 8;
    unique case (cur_r.mode)
      MODE_WINDOW: begin
        priority if (idx_r == WIN_IDX_COL) begin
          byte_cur = CMD_COLUMN;
          data_cur = 1'b0;
          pay_nxt  = cur_r.payload;
        end else if (idx_r == WIN_IDX_ROW) begin
          byte_cur = CMD_ROW;
          data_cur = 1'b0;
          pay_nxt  = cur_r.payload;
        end else if (idx_r == WIN_IDX_MEMWR) begin
          byte_cur = CMD_MEMWRITE;
          data_cur = 1'b0;
          pay_nxt  = cur_r.payload;
        end else begin
          byte_cur = cur_r.payload[PAYLOAD_W-1 -: 8];
        end
      end
      MODE_GLYPH: begin
        // high byte, then low byte and next pixel
        byte_cur = idx_r[0] ? pix_color[7:0] : pix_color[15:8];
        pay_nxt  = idx_r[0] ? (cur_r.payload << 1) : cur_r.payload;
      end
      MODE_PIXEL: begin
        data_cur = 1'b1;
      end
      MODE_RAW: begin
        data_cur = cur_r.raw_is_data;
      end
      default: begin
        data_cur = 1'b1;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
      end else if (adv && is_last) begin
        cur_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Job and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_req;
      idx_r <= '0;
    end else if (adv) begin
      cur_r.payload <= pay_nxt;
      idx_r         <= idx_r + 1'b1;
    end
    if (adv) begin
      out_byte_r    <= byte_cur;
      out_is_data_r <= data_cur;
      out_last_r    <= is_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_last    = out_last_r;

  `TFTGW_ASSERT(a_idx_bound, !cur_valid_r || (idx_r <= cur_r.last_idx), "byte index past run")
  `TFTGW_ASSERT_NEXT(a_last_mark, adv && is_last, out_valid_r && out_last_r, "run end unmarked")

endmodule

@@ rtl/core/tft_window_glyph_byte_writer.sv @@
// ----------------------------------------------------------------------------
// tft_window_glyph_byte_writer
// Turns TFT drawing requests into a tagged stream of panel bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one drawing request per transfer,
//   in_mode selects set window, glyph row, pixel or raw byte.
//   Output channel (out_valid / out_stall): one panel byte per transfer with
//   its command/data tag; out_last marks the final byte of each request.
//   Run lengths: set window 11 bytes, glyph row 32 or 2*MAX_GLYPH_WIDTH
//   bytes (width clamped to 16..32), pixel 2 bytes, raw 1 byte.
//   Throughput is one byte per cycle while out_stall is low, set by the
//   byte sequencer. On an empty path a request's first byte passes the
//   holding stage, a queue entry, the job register and the output register.
//   Requests queue in a holding stage plus a two-entry queue, so new
//   requests are taken while bytes still drain. When the receiver stalls,
//   the output byte holds and the sequencer waits; once the queue and the
//   holding stage fill, in_stall rises. Configuration (cfg_we, cfg_index,
//   cfg_wdata) must be written by the user only while idle; the block does
//   not enforce it. Synchronous reset clears the queue and output, and restores
//   the foreground color 0xFFFF, background color 0x0000 and glyph_wide 1.
// ----------------------------------------------------------------------------
module tft_window_glyph_byte_writer
  import tftgw_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic [15:0]          in_col_first,
  input  logic [15:0]          in_row_first,
  input  logic [15:0]          in_col_last,
  input  logic [15:0]          in_row_last,
  input  logic [31:0]          in_glyph_bits,
  input  logic [15:0]          in_pixel_color,
  input  logic [7:0]           in_raw_value,
  input  logic                 in_raw_is_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_is_data,
  output logic                 out_last
);

  logic [15:0] fg_rgb_r;
  logic [15:0] bg_rgb_r;
  logic        glyph_wide_r;
  cfg_t        cfg;
  logic        f_valid;
  req_t        f_req;
  logic        q_full;
  logic        q_valid;
  req_t        q_req;
  logic        q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_rgb_r     <= FG_RESET;
      bg_rgb_r     <= BG_RESET;
      glyph_wide_r <= WIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FG_RGB:     fg_rgb_r     <= cfg_wdata;
        CFG_BG_RGB:     bg_rgb_r     <= cfg_wdata;
        CFG_GLYPH_WIDE: glyph_wide_r <= cfg_wdata[0];
        default: begin
          fg_rgb_r <= fg_rgb_r;
        end
      endcase
    end
  end

  assign cfg.fg_rgb     = fg_rgb_r;
  assign cfg.bg_rgb     = bg_rgb_r;
  assign cfg.glyph_wide = glyph_wide_r;

  tftgw_front #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_col_first   (in_col_first),
    .in_row_first   (in_row_first),
    .in_col_last    (in_col_last),
    .in_row_last    (in_row_last),
    .in_glyph_bits  (in_glyph_bits),
    .in_pixel_color (in_pixel_color),
    .in_raw_value   (in_raw_value),
    .in_raw_is_data (in_raw_is_data),
    .f_valid        (f_valid),
    .f_req          (f_req),
    .q_full         (q_full)
  );

  tftgw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .f_valid (f_valid),
    .f_req   (f_req),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  tftgw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last)
  );

endmodule

@@ tb/tft_window_glyph_byte_writer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tft_window_glyph_byte_writer_tb
// Self-checking bench for the TFT window/glyph byte writer. Drawing requests
// (set window, glyph row, pixel, raw byte) are sent in random bursts; a
// predictor expands each accepted request into its tagged panel bytes and the
// monitor compares every output transfer against the oldest expected byte.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tft_window_glyph_byte_writer_tb
  import tftgw_pkg::*;
();

  localparam int GLYPH_MAX = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 27;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_MAX = 10;
  // Longest quiet stretch in a good run is the long receiver hold-off;
  // the sender gaps and stall patterns are far shorter.
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    mode_t       mode;
    logic [15:0] col_first;
    logic [15:0] row_first;
    logic [15:0] col_last;
    logic [15:0] row_last;
    logic [31:0] glyph_bits;
    logic [15:0] pixel_color;
    logic [7:0]  raw_value;
    logic        raw_is_data;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } panel_byte_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode = '0;
  logic [15:0]          in_col_first = '0;
  logic [15:0]          in_row_first = '0;
  logic [15:0]          in_col_last = '0;
  logic [15:0]          in_row_last = '0;
  logic [31:0]          in_glyph_bits = '0;
  logic [15:0]          in_pixel_color = '0;
  logic [7:0]           in_raw_value = '0;
  logic                 in_raw_is_data = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_is_data;
  logic                 out_last;

  // Bench state
  draw_req_t   draw_q[$];
  panel_byte_t panel_bytes_q[$];
  draw_req_t   cur_req;
  logic [15:0] fg_rgb = FG_RESET;
  logic [15:0] bg_rgb = BG_RESET;
  logic        wide_glyph = WIDE_RESET;
  int          err_count = 0;
  bit          long_hold_req = 1'b0;

  tft_window_glyph_byte_writer #(
    .MAX_GLYPH_WIDTH(GLYPH_MAX)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_col_first  (in_col_first),
    .in_row_first  (in_row_first),
    .in_col_last   (in_col_last),
    .in_row_last   (in_row_last),
    .in_glyph_bits (in_glyph_bits),
    .in_pixel_color(in_pixel_color),
    .in_raw_value  (in_raw_value),
    .in_raw_is_data(in_raw_is_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_is_data   (out_is_data),
    .out_last      (out_last)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: expected panel bytes for one request under the current settings
  // ---------------------------------------------------------------------------
  task automatic queue_panel_byte(input logic [7:0] value, input logic is_data,
                                  input logic is_last);
    panel_byte_t pb;
    pb.value   = value;
    pb.is_data = is_data;
    pb.last    = is_last;
    panel_bytes_q.push_back(pb);
  endtask

  // 16-bit word as two data bytes, high byte first
  task automatic queue_data_word(input logic [15:0] word, input logic is_last);
    queue_panel_byte(word[15:8], 1'b1, 1'b0);
    queue_panel_byte(word[7:0], 1'b1, is_last);
  endtask

  task automatic expand_request(input draw_req_t req);
    int width;
    int pos;
    case (req.mode)
      MODE_WINDOW: begin
        // coordinates pass through untouched, even when first > last
        queue_panel_byte(CMD_COLUMN, 1'b0, 1'b0);
        queue_data_word(req.col_first, 1'b0);
        queue_data_word(req.col_last, 1'b0);
        queue_panel_byte(CMD_ROW, 1'b0, 1'b0);
        queue_data_word(req.row_first, 1'b0);
        queue_data_word(req.row_last, 1'b0);
        queue_panel_byte(CMD_MEMWRITE, 1'b0, 1'b1);
      end
      MODE_GLYPH: begin
        // narrow rows ignore the upper half; leftmost pixel is the top used bit
        width = wide_glyph ? GLYPH_MAX : 16;
        for (int col = 0; col < width; col++) begin
          pos = width - 1 - col;
          queue_data_word(req.glyph_bits[pos] ? fg_rgb : bg_rgb, col == width - 1);
        end
      end
      MODE_PIXEL: queue_data_word(req.pixel_color, 1'b1);
      default:    queue_panel_byte(req.raw_value, req.raw_is_data, 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests from draw_q with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_request(cur_req);
      end
      if (in_valid && in_stall) begin
        // stalled payload holds
      end else if (gap_left > 0 || draw_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur_req = draw_q.pop_front();
        in_mode        <= cur_req.mode;
        in_col_first   <= cur_req.col_first;
        in_row_first   <= cur_req.row_first;
        in_col_last    <= cur_req.col_last;
        in_row_last    <= cur_req.row_last;
        in_glyph_bits  <= cur_req.glyph_bits;
        in_pixel_color <= cur_req.pixel_color;
        in_raw_value   <= cur_req.raw_value;
        in_raw_is_data <= cur_req.raw_is_data;
        in_valid       <= 1'b1;
        // end of burst: pick the next burst length and maybe a gap
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each output transfer, drive out_stall on its own pattern
  // ---------------------------------------------------------------------------
  stall_style_t stall_style = STALL_NONE;
  int           style_left = 0;
  int           hold_left = 0;
  int           stall_tick = 0;

  always @(posedge clk) begin
    panel_byte_t got;
    panel_byte_t want;
    logic        stall_now;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_byte, out_is_data, out_last};
        if (panel_bytes_q.size() == 0) begin
          if (err_count < REPORT_MAX)
            $display("%0t: unexpected byte %02h data %0b last %0b", $realtime,
                     got.value, got.is_data, got.last);
          err_count++;
        end else begin
          want = panel_bytes_q.pop_front();
          if (got !== want) begin
            if (err_count < REPORT_MAX)
              $display({"%0t: byte mismatch: expected %02h data %0b last %0b, ",
                        "got %02h data %0b last %0b"},
                       $realtime, want.value, want.is_data, want.last,
                       got.value, got.is_data, got.last);
            err_count++;
          end
        end
      end

      // long hold-off on request, otherwise a changing stall pattern
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 120);
      end else begin
        style_left--;
      end
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else begin
        case (stall_style)
          STALL_LIGHT:    stall_now = ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    stall_now = ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: stall_now = (stall_tick % 3 == 0);
          default:        stall_now = 1'b0;
        endcase
      end
      out_stall <= stall_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run after too many cycles without any transfer
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // all fields random; the ones the mode does not use must be ignored
  function automatic draw_req_t random_request(input mode_t mode);
    draw_req_t r;
    r.mode        = mode;
    r.col_first   = 16'($urandom);
    r.row_first   = 16'($urandom);
    r.col_last    = 16'($urandom);
    r.row_last    = 16'($urandom);
    r.glyph_bits  = $urandom;
    r.pixel_color = 16'($urandom);
    r.raw_value   = 8'($urandom);
    r.raw_is_data = 1'($urandom);
    return r;
  endfunction

  // sender has stopped and every expected byte has come out
  task automatic wait_drained();
    while (draw_q.size() != 0 || in_valid || panel_bytes_q.size() != 0)
      @(posedge clk);
  endtask

  // write all registers back to back; optionally hit the unused index first
  task automatic program_regs(input logic [15:0] fg, input logic [15:0] bg,
                              input logic wide, input bit stray);
    if (stray) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_UNUSED_IDX;
      cfg_wdata <= 16'($urandom);
    end
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FG_RGB;
    cfg_wdata <= fg;
    fg_rgb = fg;
    @(posedge clk);
    cfg_index <= CFG_BG_RGB;
    cfg_wdata <= bg;
    bg_rgb = bg;
    @(posedge clk);
    cfg_index <= CFG_GLYPH_WIDE;
    cfg_wdata <= {15'($urandom), wide};
    wide_glyph = wide;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    draw_req_t   r;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        wide;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: window extremes and reversed order
    r = random_request(MODE_WINDOW);
    r.col_first = '0; r.col_last = '0; r.row_first = '0; r.row_last = '0;
    draw_q.push_back(r);
    r.col_first = '1; r.col_last = '1; r.row_first = '1; r.row_last = '1;
    draw_q.push_back(r);
    r.col_first = 16'h1234; r.col_last = 16'h0012; r.row_first = 16'hFF00; r.row_last = 16'h00FF;
    draw_q.push_back(r);
    r.col_first = 16'hAAAA; r.col_last = 16'h5555; r.row_first = 16'h5555; r.row_last = 16'hAAAA;
    draw_q.push_back(r);
    // wide glyph rows
    r = random_request(MODE_GLYPH); r.glyph_bits = '0;           draw_q.push_back(r);
    r = random_request(MODE_GLYPH); r.glyph_bits = '1;           draw_q.push_back(r);
    r = random_request(MODE_GLYPH); r.glyph_bits = 32'h80000001; draw_q.push_back(r);
    r = random_request(MODE_GLYPH); r.glyph_bits = 32'hAAAA5555; draw_q.push_back(r);
    // pixels
    r = random_request(MODE_PIXEL); r.pixel_color = '0;          draw_q.push_back(r);
    r = random_request(MODE_PIXEL); r.pixel_color = '1;          draw_q.push_back(r);
    r = random_request(MODE_PIXEL); r.pixel_color = 16'h8001;    draw_q.push_back(r);
    // raw bytes, both tags
    r = random_request(MODE_RAW); r.raw_value = 8'h00; r.raw_is_data = 1'b0; draw_q.push_back(r);
    r = random_request(MODE_RAW); r.raw_value = 8'hFF; r.raw_is_data = 1'b1; draw_q.push_back(r);
    r = random_request(MODE_RAW); r.raw_value = 8'h80; r.raw_is_data = 1'b0; draw_q.push_back(r);
    r = random_request(MODE_RAW); r.raw_value = 8'h7F; r.raw_is_data = 1'b1; draw_q.push_back(r);
    r = random_request(MODE_RAW); r.raw_value = CMD_COLUMN; r.raw_is_data = 1'b1;
    draw_q.push_back(r);
    wait_drained();

    // Directed, narrow glyphs with swapped extreme colors: upper half ignored
    program_regs(16'h0000, 16'hFFFF, 1'b0, 1'b1);
    r = random_request(MODE_GLYPH); r.glyph_bits = 32'hFFFF0000; draw_q.push_back(r);
    r = random_request(MODE_GLYPH); r.glyph_bits = 32'h0000FFFF; draw_q.push_back(r);
    r = random_request(MODE_GLYPH); r.glyph_bits = 32'h00018000; draw_q.push_back(r);
    r = random_request(MODE_GLYPH);                              draw_q.push_back(r);
    r = random_request(MODE_WINDOW);                             draw_q.push_back(r);
    wait_drained();

    // Random phases, each with its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 3)
        0: begin fg = 16'hFFFF; bg = 16'h0000; wide = 1'b1; end
        1: begin fg = 16'h0000; bg = 16'hFFFF; wide = 1'b0; end
        default: begin fg = 16'($urandom); bg = 16'($urandom); wide = 1'($urandom); end
      endcase
      program_regs(fg, bg, wide, 1'($urandom));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = random_request(mode_t'($urandom_range(0, 3)));
        if (r.mode == MODE_GLYPH && $urandom_range(0, 7) == 0)
          r.glyph_bits = $urandom_range(0, 1) ? '1 : '0;
        draw_q.push_back(r);
      end
      // receiver holds off while requests keep coming, so the input backs up
      if (phase == 1) long_hold_req = 1'b1;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
